/* rtl/core/ffscg_pkg.sv */
// Package for the cylinder-group free count checker.
// Holds the transaction payload types, command and register codes, and the
// saturating counter helper. Depends on nothing.
`default_nettype none

package ffscg_pkg;

  // Counter and recorded count width.
  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration port sizes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_LOG2        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_FRAGS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INODES_PER_GROUP = 2'd2;

  // Input commands.
  localparam logic [1:0] CMD_INODE = 2'd0;
  localparam logic [1:0] CMD_FRAG  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       bitmap_byte;
    logic [CNT_W-1:0] recorded_free_blocks;
    logic [CNT_W-1:0] recorded_free_frags;
    logic [CNT_W-1:0] recorded_free_inodes;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] free_frags;
    logic [CNT_W-1:0] free_inodes;
    logic             blocks_mismatch;
    logic             frags_mismatch;
    logic             inodes_mismatch;
  } out_item_t;

  // Per-byte increments from the byte evaluator.
  typedef struct packed {
    logic [3:0] inode_inc;
    logic [3:0] block_inc;
    logic [3:0] frag_inc;
    logic       inode_live;
    logic       frag_live;
  } byte_eval_t;

  // Add a small increment to a counter, saturating at the all-ones value.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [3:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ffscg_byte_eval.sv */
// Per-byte evaluation for the cylinder-group free count checker.
// Masks one bitmap byte against the configured limits and counts free
// inodes, whole free blocks and loose free fragments. Depends on ffscg_pkg.
`default_nettype none

module ffscg_byte_eval
  import ffscg_pkg::*;
#(
  parameter int MAX_GROUP_BITS = 524288,
  localparam int POS_LIMIT = (MAX_GROUP_BITS + 7) / 8,
  localparam int POS_W = $clog2(POS_LIMIT + 1)
) (
  input  wire logic [7:0]       bitmap_byte,
  input  wire logic [POS_W-1:0] inode_pos,
  input  wire logic [POS_W-1:0] frag_pos,
  input  wire logic [1:0]       frag_log2,
  input  wire logic [CNT_W-1:0] group_frags,
  input  wire logic [CNT_W-1:0] inodes_per_group,
  output byte_eval_t            eval
);

  localparam int CMP_W = ((POS_W + 3 > CNT_W) ? POS_W + 3 : CNT_W) + 1;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_GROUP_BITS);

  // Limits clamped to the largest group size.
  logic [CMP_W-1:0] ilim;
  logic [CMP_W-1:0] flim;
  logic [CMP_W-1:0] whole_end;

  // Per-byte results before they are packed into the output struct.
  logic [3:0] inode_inc;
  logic       inode_live;
  logic [3:0] block_inc;
  logic [3:0] frag_inc;
  logic       frag_live;

  always_comb begin
    ilim = (CMP_W'(inodes_per_group) > MAX_C) ? MAX_C : CMP_W'(inodes_per_group);
    flim = (CMP_W'(group_frags) > MAX_C) ? MAX_C : CMP_W'(group_frags);
    // Fragments at or above this index do not belong to a whole block.
    whole_end = (flim >> frag_log2) << frag_log2;
  end

  // Free inodes: clear bits whose index is below the inode limit.
  always_comb begin
    logic [CMP_W-1:0] ibase;
    logic [3:0]       n;
    ibase = CMP_W'({inode_pos, 3'b000});
    n = 4'd0;
    for (int j = 0; j < 8; j++) begin
      if (((ibase + CMP_W'(j)) < ilim) && !bitmap_byte[j]) begin
        n = n + 4'd1;
      end
    end
    inode_inc  = n;
    inode_live = (inode_pos < POS_W'(POS_LIMIT));
  end

  // Free blocks and fragments: each bit looks at the block it belongs to.
  always_comb begin
    logic [CMP_W-1:0] fbase;
    logic [3:0]       per;
    logic [8:0]       gmask9;
    logic [2:0]       st_mask;
    logic [2:0]       start;
    logic [7:0]       grp;
    logic             full;
    logic             whole;
    logic [3:0]       nb;
    logic [3:0]       nf;
    fbase   = CMP_W'({frag_pos, 3'b000});
    per     = 4'd1 << frag_log2;
    gmask9  = (9'd1 << per) - 9'd1;
    st_mask = 3'(per - 4'd1);
    nb = 4'd0;
    nf = 4'd0;
    for (int j = 0; j < 8; j++) begin
      start = 3'(j) & ~st_mask;
      grp   = gmask9[7:0] << start;
      full  = ((bitmap_byte & grp) == grp);
      whole = ((fbase + CMP_W'(start)) < whole_end);
      if (whole) begin
        // A fully free block counts once, at its first fragment.
        if (full && (3'(j) == start)) begin
          nb = nb + 4'd1;
        end else if (!full && bitmap_byte[j]) begin
          nf = nf + 4'd1;
        end
      end else if (bitmap_byte[j] && ((fbase + CMP_W'(j)) < flim)) begin
        nf = nf + 4'd1;
      end
    end
    block_inc = nb;
    frag_inc  = nf;
    frag_live = (frag_pos < POS_W'(POS_LIMIT));
  end

  // Pack the per-byte results.
  always_comb begin
    eval.inode_inc  = inode_inc;
    eval.block_inc  = block_inc;
    eval.frag_inc   = frag_inc;
    eval.inode_live = inode_live;
    eval.frag_live  = frag_live;
  end

endmodule

`default_nettype wire

/* rtl/core/ffs_cg_bitmap_free_counter.sv */
// Top level of the cylinder-group free count checker.
// Holds the input register, running counters, configuration and result
// register. Depends on ffscg_pkg and ffscg_byte_eval.
//
// The block takes one bitmap byte or end-of-group transaction per clock
// while it is not stalled: each transaction is held in the input register,
// where the byte evaluator and the saturating counters update, and an
// end-of-group result is then registered in the output register. Input is
// stalled only while an end transaction waits for a full output register
// that is itself stalled. Inode and fragment bytes past MAX_GROUP_BITS bits
// are dropped, and the end transaction clears all counters and byte
// positions.
`default_nettype none

module ffs_cg_bitmap_free_counter
  import ffscg_pkg::*;
#(
  parameter int MAX_GROUP_BITS = 524288
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_LIMIT = (MAX_GROUP_BITS + 7) / 8;
  localparam int POS_W = $clog2(POS_LIMIT + 1);

  // Configuration registers.
  logic [1:0]       frag_log2_r, frag_log2_nxt;
  logic [CNT_W-1:0] group_frags_r, group_frags_nxt;
  logic [CNT_W-1:0] inodes_per_group_r, inodes_per_group_nxt;

  // Input stage.
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r, s1_item_nxt;

  // Running state.
  logic [POS_W-1:0] inode_pos_r, inode_pos_nxt;
  logic [POS_W-1:0] frag_pos_r, frag_pos_nxt;
  logic [CNT_W-1:0] block_cnt_r, block_cnt_nxt;
  logic [CNT_W-1:0] frag_cnt_r, frag_cnt_nxt;
  logic [CNT_W-1:0] inode_cnt_r, inode_cnt_nxt;

  // Result stage.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic       out_free;
  logic       s1_go;
  logic       in_accept;
  byte_eval_t eval;

  // Byte evaluator on the held input transaction.
  ffscg_byte_eval #(
    .MAX_GROUP_BITS (MAX_GROUP_BITS)
  ) u_byte_eval (
    .bitmap_byte      (s1_item_r.bitmap_byte),
    .inode_pos        (inode_pos_r),
    .frag_pos         (frag_pos_r),
    .frag_log2        (frag_log2_r),
    .group_frags      (group_frags_r),
    .inodes_per_group (inodes_per_group_r),
    .eval             (eval)
  );

  // Handshake: the input stage moves on unless an end result cannot be stored.
  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    s1_go     = s1_valid_r && ((s1_item_r.cmd != CMD_END) || out_free);
    in_stall  = s1_valid_r && !s1_go;
    in_accept = in_valid && !in_stall;
    out_valid = out_valid_r;
    out_data  = out_item_r;
  end

  // Configuration writes.
  always_comb begin
    frag_log2_nxt        = frag_log2_r;
    group_frags_nxt      = group_frags_r;
    inodes_per_group_nxt = inodes_per_group_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAG_LOG2:        frag_log2_nxt        = cfg_wdata[1:0];
        REG_GROUP_FRAGS:      group_frags_nxt      = cfg_wdata[CNT_W-1:0];
        REG_INODES_PER_GROUP: inodes_per_group_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register load.
  always_comb begin
    s1_item_nxt = s1_item_r;
    if (in_accept) begin
      s1_item_nxt = in_data;
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Counter updates and result capture for the transaction in the input stage.
  always_comb begin
    inode_pos_nxt = inode_pos_r;
    frag_pos_nxt  = frag_pos_r;
    block_cnt_nxt = block_cnt_r;
    frag_cnt_nxt  = frag_cnt_r;
    inode_cnt_nxt = inode_cnt_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_go) begin
      case (s1_item_r.cmd)
        CMD_INODE: begin
          if (eval.inode_live) begin
            inode_pos_nxt = inode_pos_r + POS_W'(1);
            inode_cnt_nxt = sat_add(inode_cnt_r, eval.inode_inc);
          end
        end
        CMD_FRAG: begin
          if (eval.frag_live) begin
            frag_pos_nxt  = frag_pos_r + POS_W'(1);
            block_cnt_nxt = sat_add(block_cnt_r, eval.block_inc);
            frag_cnt_nxt  = sat_add(frag_cnt_r, eval.frag_inc);
          end
        end
        CMD_END: begin
          out_item_nxt.free_blocks     = block_cnt_r;
          out_item_nxt.free_frags      = frag_cnt_r;
          out_item_nxt.free_inodes     = inode_cnt_r;
          out_item_nxt.blocks_mismatch = (block_cnt_r != s1_item_r.recorded_free_blocks);
          out_item_nxt.frags_mismatch  = (frag_cnt_r != s1_item_r.recorded_free_frags);
          out_item_nxt.inodes_mismatch = (inode_cnt_r != s1_item_r.recorded_free_inodes);
          out_valid_nxt = 1'b1;
          inode_pos_nxt = '0;
          frag_pos_nxt  = '0;
          block_cnt_nxt = '0;
          frag_cnt_nxt  = '0;
          inode_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_log2_r        <= 2'd3;
      group_frags_r      <= '0;
      inodes_per_group_r <= '0;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      inode_pos_r        <= '0;
      frag_pos_r         <= '0;
      block_cnt_r        <= '0;
      frag_cnt_r         <= '0;
      inode_cnt_r        <= '0;
    end else begin
      frag_log2_r        <= frag_log2_nxt;
      group_frags_r      <= group_frags_nxt;
      inodes_per_group_r <= inodes_per_group_nxt;
      s1_valid_r         <= s1_valid_nxt;
      out_valid_r        <= out_valid_nxt;
      inode_pos_r        <= inode_pos_nxt;
      frag_pos_r         <= frag_pos_nxt;
      block_cnt_r        <= block_cnt_nxt;
      frag_cnt_r         <= frag_cnt_nxt;
      inode_cnt_r        <= inode_cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire
